FILE: hw/rtl/gnum_pkg.sv
`default_nettype none

package gnum_pkg;

  localparam int SIZE_W  = 9;
  localparam int NUM_W   = 24;
  localparam int COORD_W = 8;
  localparam int DIMS_W  = 2;
  localparam int IDX_W   = 2;

  localparam int MAX_AXIS_DEFAULT = 256;

  localparam logic [IDX_W-1:0] REG_X_COUNT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_Y_COUNT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_Z_COUNT  = 2'd2;
  localparam logic [IDX_W-1:0] REG_MIN_DIMS = 2'd3;

  typedef struct packed {
    logic [NUM_W-1:0]   element_number;
    logic [COORD_W-1:0] coord_i;
    logic [COORD_W-1:0] coord_j;
    logic [COORD_W-1:0] coord_k;
    logic [DIMS_W-1:0]  grid_dims;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/grid_element_numbering_top.sv
// Channel   Valid      Stall      Word
// input     in_valid   in_stall   restart
// output    out_valid  out_stall  element_number, coord_i/j/k, grid_dims, last
// config    wr_en      (none)     wr_index, wr_data
//
// One word is accepted every cycle while in_stall is low; its result is registered.
// The position counters are updated in the same cycle the word is accepted.
// A two-entry output buffer lets the input run on while one result waits; in_stall
// rises only when both entries are full and comes straight from a register.
// Synchronous reset clears the positions, the sizes to 1 and the minimum to 0.
`default_nettype none

module grid_element_numbering_top #(
  parameter int MAX_AXIS = gnum_pkg::MAX_AXIS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic [gnum_pkg::IDX_W-1:0]   wr_index,
  input  wire logic [gnum_pkg::SIZE_W-1:0]  wr_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         restart,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [gnum_pkg::NUM_W-1:0]        element_number,
  output logic [gnum_pkg::COORD_W-1:0]      coord_i,
  output logic [gnum_pkg::COORD_W-1:0]      coord_j,
  output logic [gnum_pkg::COORD_W-1:0]      coord_k,
  output logic [gnum_pkg::DIMS_W-1:0]       grid_dims,
  output logic                              last
);
  import gnum_pkg::*;

  localparam int SIZE_MAX  = (1 << SIZE_W) - 1;
  localparam int MAX_CLAMP = (MAX_AXIS > SIZE_MAX) ? SIZE_MAX : MAX_AXIS;
  localparam int PW        = $clog2(MAX_CLAMP);

  logic [SIZE_W-1:0] x_count;
  logic [SIZE_W-1:0] y_count;
  logic [SIZE_W-1:0] z_count;
  logic [DIMS_W-1:0] min_dims;

  logic [PW-1:0]     pos [3];
  logic [NUM_W-1:0]  running_number;
  logic [PW-1:0]     pos_next [3];
  logic [NUM_W-1:0]  running_number_next;

  logic [SIZE_W-1:0] raw [3];
  logic [SIZE_W-1:0] n [3];
  logic [PW-1:0]     cur [3];
  logic [NUM_W-1:0]  cur_number;
  logic [PW:0]       inc [3];
  logic [2:0]        is_fast;
  logic [2:0]        is_mid;
  logic [2:0]        is_slow;
  logic [2:0]        at_end;
  logic [2:0]        big;
  logic              stale;
  logic              clear;
  logic              is_last;
  logic              wrap_fast;
  logic              wrap_mid;
  logic [DIMS_W-1:0] dims_cnt;
  logic [DIMS_W-1:0] dims;
  logic              accept;
  logic              take_out;
  result_t           res;
  result_t           out_word;
  result_t           skid_word;
  logic              skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count  <= SIZE_W'(1);
      y_count  <= SIZE_W'(1);
      z_count  <= SIZE_W'(1);
      min_dims <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_X_COUNT:  x_count  <= wr_data;
        REG_Y_COUNT:  y_count  <= wr_data;
        REG_Z_COUNT:  z_count  <= wr_data;
        REG_MIN_DIMS: min_dims <= wr_data[DIMS_W-1:0];
        default:      ;
      endcase
    end
  end

  assign raw[0] = x_count;
  assign raw[1] = y_count;
  assign raw[2] = z_count;

  always_comb begin
    stale = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (raw[a] == '0) begin
        n[a] = SIZE_W'(1);
      end else if (raw[a] > SIZE_W'(MAX_CLAMP)) begin
        n[a] = SIZE_W'(MAX_CLAMP);
      end else begin
        n[a] = raw[a];
      end
      big[a] = (n[a] > SIZE_W'(1));
      if (SIZE_W'(pos[a]) >= n[a]) begin
        stale = 1'b1;
      end
    end
  end

  assign clear = restart | stale;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cur[a]    = clear ? '0 : pos[a];
      inc[a]    = {1'b0, cur[a]} + (PW+1)'(1);
      at_end[a] = ((PW+1)'(n[a]) == inc[a]);
    end
    cur_number = clear ? '0 : running_number;
  end

  assign is_last = &at_end;

  always_comb begin
    dims_cnt = DIMS_W'(big[0]) + DIMS_W'(big[1]) + DIMS_W'(big[2]);
    dims     = (dims_cnt == '0) ? DIMS_W'(1) : dims_cnt;
    if (dims < min_dims) begin
      dims = min_dims;
    end
  end

  always_comb begin
    if (n[0] > n[1]) begin
      if (n[0] > n[2]) begin
        if (n[1] > n[2]) begin
          is_fast = 3'b100; is_mid = 3'b010; is_slow = 3'b001;
        end else begin
          is_fast = 3'b010; is_mid = 3'b100; is_slow = 3'b001;
        end
      end else begin
        is_fast = 3'b010; is_mid = 3'b001; is_slow = 3'b100;
      end
    end else if (n[0] > n[2]) begin
      is_fast = 3'b100; is_mid = 3'b001; is_slow = 3'b010;
    end else if (n[1] > n[2]) begin
      is_fast = 3'b001; is_mid = 3'b100; is_slow = 3'b010;
    end else begin
      is_fast = 3'b001; is_mid = 3'b010; is_slow = 3'b100;
    end
  end

  assign wrap_fast = |(is_fast & at_end);
  assign wrap_mid  = wrap_fast & (|(is_mid & at_end));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (is_last) begin
        pos_next[a] = '0;
      end else if (is_fast[a]) begin
        pos_next[a] = wrap_fast ? '0 : inc[a][PW-1:0];
      end else if (is_mid[a]) begin
        if (wrap_mid) begin
          pos_next[a] = '0;
        end else begin
          pos_next[a] = wrap_fast ? inc[a][PW-1:0] : cur[a];
        end
      end else begin
        pos_next[a] = (wrap_mid & is_slow[a]) ? inc[a][PW-1:0] : cur[a];
      end
    end
    running_number_next = is_last ? '0 : cur_number + NUM_W'(1);
  end

  always_comb begin
    res.element_number = cur_number;
    res.coord_i        = COORD_W'(cur[0]);
    res.coord_j        = COORD_W'(cur[1]);
    res.coord_k        = COORD_W'(cur[2]);
    res.grid_dims      = dims;
    res.last           = is_last;
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid & ~skid_valid;
  assign take_out = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        pos[a] <= '0;
      end
      running_number <= '0;
    end else if (accept) begin
      for (int a = 0; a < 3; a++) begin
        pos[a] <= pos_next[a];
      end
      running_number <= running_number_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take_out) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take_out) begin
        out_word  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= res;
        skid_valid <= 1'b1;
      end
    end else if (take_out) begin
      out_valid <= 1'b0;
    end
  end

  assign element_number = out_word.element_number;
  assign coord_i        = out_word.coord_i;
  assign coord_j        = out_word.coord_j;
  assign coord_k        = out_word.coord_k;
  assign grid_dims      = out_word.grid_dims;
  assign last           = out_word.last;

endmodule

`default_nettype wire

FILE: hw/rtl/gnum_checker.sv
`default_nettype none

module gnum_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic [gnum_pkg::NUM_W-1:0]   element_number,
  input  wire logic [gnum_pkg::COORD_W-1:0] coord_i,
  input  wire logic [gnum_pkg::COORD_W-1:0] coord_j,
  input  wire logic [gnum_pkg::COORD_W-1:0] coord_k,
  input  wire logic [gnum_pkg::DIMS_W-1:0]  grid_dims,
  input  wire logic                         last
);

  // The input only stalls when a result is already waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word gave no result");

  a_dims_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (grid_dims != '0))
    else $error("grid_dims reported as zero");

  // Element zero always sits at the grid origin.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && element_number == '0) |-> (coord_i == '0 && coord_j == '0 && coord_k == '0))
    else $error("element zero not at the origin");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(element_number) && $stable(last)))
    else $error("stalled output word changed");

endmodule

bind grid_element_numbering_top gnum_checker u_gnum_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .element_number (element_number),
  .coord_i        (coord_i),
  .coord_j        (coord_j),
  .coord_k        (coord_k),
  .grid_dims      (grid_dims),
  .last           (last)
);

`default_nettype wire

FILE: tb/grid_order_checker.sv
module grid_order_checker
  import gnum_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_index,
  input  wire logic [SIZE_W-1:0]  wr_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic               restart,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [NUM_W-1:0]   element_number,
  input  wire logic [COORD_W-1:0] coord_i,
  input  wire logic [COORD_W-1:0] coord_j,
  input  wire logic [COORD_W-1:0] coord_k,
  input  wire logic [DIMS_W-1:0]  grid_dims,
  input  wire logic               last,
  output int                      errors,
  output int                      pending,
  output int                      checked,
  output int                      wraps
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AXIS_LIMIT = MAX_AXIS_DEFAULT;

  logic [SIZE_W-1:0] size_reg [3];
  logic [1:0]        dims_floor;
  int                pos [3];
  int                seq_num;
  result_t           expected_elements [$];

  function automatic int usable_size(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > AXIS_LIMIT) return AXIS_LIMIT;
    return s;
  endfunction

  // Emits the element at the current position and moves the position on
  // along the axis order that the sizes select.
  task automatic next_element(input logic rs, output result_t r);
    int n [3];
    int p [3];
    int fast, mid, slow;
    int dims;
    for (int a = 0; a < 3; a++) n[a] = usable_size(size_reg[a]);
    if (rs || pos[0] >= n[0] || pos[1] >= n[1] || pos[2] >= n[2]) begin
      pos = '{0, 0, 0};
      seq_num = 0;
    end
    dims = (n[0] > 1) + (n[1] > 1) + (n[2] > 1);
    if (dims == 0) dims = 1;
    if (dims < dims_floor) dims = dims_floor;
    r.element_number = seq_num[NUM_W-1:0];
    r.coord_i = pos[0][COORD_W-1:0];
    r.coord_j = pos[1][COORD_W-1:0];
    r.coord_k = pos[2][COORD_W-1:0];
    r.grid_dims = dims[DIMS_W-1:0];
    r.last = (pos[0] == n[0] - 1) && (pos[1] == n[1] - 1) && (pos[2] == n[2] - 1);
    if (n[0] > n[1]) begin
      if (n[0] > n[2]) begin
        slow = 0;
        if (n[1] > n[2]) begin
          fast = 2; mid = 1;
        end else begin
          fast = 1; mid = 2;
        end
      end else begin
        fast = 1; mid = 0; slow = 2;
      end
    end else if (n[0] > n[2]) begin
      fast = 2; mid = 0; slow = 1;
    end else if (n[1] > n[2]) begin
      fast = 0; mid = 2; slow = 1;
    end else begin
      fast = 0; mid = 1; slow = 2;
    end
    if (r.last) begin
      pos = '{0, 0, 0};
      seq_num = 0;
    end else begin
      p = pos;
      p[fast]++;
      if (p[fast] >= n[fast]) begin
        p[fast] = 0;
        p[mid]++;
      end
      if (p[mid] >= n[mid]) begin
        p[mid] = 0;
        p[slow]++;
      end
      pos = p;
      seq_num = (seq_num + 1) & 32'hFF_FFFF;
    end
  endtask

  function automatic int field_differs(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      size_reg = '{1, 1, 1};
      dims_floor = 0;
      pos = '{0, 0, 0};
      seq_num = 0;
      expected_elements.delete();
      errors = 0;
      checked = 0;
      wraps = 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_elements.size() == 0) begin
          $display("%0t: unexpected word, element %0d at (%0d,%0d,%0d)", $time,
                   element_number, coord_i, coord_j, coord_k);
          errors++;
        end else begin
          want = expected_elements.pop_front();
          errors += field_differs("element_number", want.element_number, element_number);
          errors += field_differs("coord_i", want.coord_i, coord_i);
          errors += field_differs("coord_j", want.coord_j, coord_j);
          errors += field_differs("coord_k", want.coord_k, coord_k);
          errors += field_differs("grid_dims", want.grid_dims, grid_dims);
          errors += field_differs("last", want.last, last);
          if (last) wraps++;
        end
      end
      if (wr_en) begin
        case (wr_index)
          REG_X_COUNT:  size_reg[0] = wr_data;
          REG_Y_COUNT:  size_reg[1] = wr_data;
          REG_Z_COUNT:  size_reg[2] = wr_data;
          REG_MIN_DIMS: dims_floor = wr_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        next_element(restart, want);
        expected_elements.push_back(want);
      end
    end
    pending = expected_elements.size();
  end

endmodule

FILE: tb/tb.sv
module tb
  import gnum_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_WORDS = 600;

  logic               clk;
  logic               rst;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_index;
  logic [SIZE_W-1:0]  wr_data;
  logic               in_valid;
  logic               in_stall;
  logic               restart;
  logic               out_valid;
  logic               out_stall;
  logic [NUM_W-1:0]   element_number;
  logic [COORD_W-1:0] coord_i;
  logic [COORD_W-1:0] coord_j;
  logic [COORD_W-1:0] coord_k;
  logic [DIMS_W-1:0]  grid_dims;
  logic               last;

  int errors, pending, checked, wraps;
  int words_sent, settings_used;
  int burst_left;
  int idle_cycles;
  int stall_mode, mode_left, stall_run;

  grid_element_numbering_top dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .element_number(element_number), .coord_i(coord_i), .coord_j(coord_j),
    .coord_k(coord_k), .grid_dims(grid_dims), .last(last)
  );

  grid_order_checker checker_i (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .element_number(element_number), .coord_i(coord_i), .coord_j(coord_j),
    .coord_k(coord_k), .grid_dims(grid_dims), .last(last),
    .errors(errors), .pending(pending), .checked(checked), .wraps(wraps)
  );

  always #6 clk = ~clk;

  // The receiver switches between free running, scattered stalls and long stall runs.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
      stall_run = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (stall_mode == 1) begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end else if (stall_mode == 2 && $urandom_range(0, 15) == 0) begin
        stall_run = $urandom_range(5, 20);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_word(input logic rs);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (in_stall);
    burst_left--;
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    settings_used++;
  endtask

  task automatic set_reg(input logic [IDX_W-1:0] idx, input int value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value[SIZE_W-1:0];
    @(posedge clk);
  endtask

  function automatic int grid_side(int s);
    if (s == 0) return 1;
    if (s > MAX_AXIS_DEFAULT) return MAX_AXIS_DEFAULT;
    return s;
  endfunction

  function automatic int pick_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(257, 511);
    if (sel == 2) return $urandom_range(200, 256);
    return $urandom_range(1, 6);
  endfunction

  initial begin
    int sz [3];
    int grid_total, count, start_count;
    clk = 1'b0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_valid = 1'b0;
    restart = 1'b0;
    out_stall = 1'b0;
    words_sent = 0;
    settings_used = 0;
    burst_left = 0;
    idle_cycles = 0;
    sz = '{1, 1, 1};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset grid of a single cell: every word is the last one.
    send_word(1'b0);
    send_word(1'b0);

    // Sizes of zero act as one, and the minimum lifts the reported dimensionality.
    drain();
    set_reg(REG_X_COUNT, 0);
    set_reg(REG_Y_COUNT, 0);
    set_reg(REG_Z_COUNT, 0);
    set_reg(REG_MIN_DIMS, 3);
    wr_en <= 1'b0;
    send_word(1'b0);
    send_word(1'b1);

    // A small grid run past its end to see the wrap.
    drain();
    set_reg(REG_X_COUNT, 2);
    set_reg(REG_Y_COUNT, 2);
    set_reg(REG_Z_COUNT, 1);
    set_reg(REG_MIN_DIMS, 0);
    wr_en <= 1'b0;
    repeat (5) send_word(1'b0);

    // Oversized axes are clipped to the largest legal size.
    drain();
    set_reg(REG_X_COUNT, 511);
    set_reg(REG_Y_COUNT, 257);
    set_reg(REG_Z_COUNT, 256);
    set_reg(REG_MIN_DIMS, 1);
    wr_en <= 1'b0;
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);

    // Shrinking the grid under a running position forces a fresh start.
    drain();
    set_reg(REG_X_COUNT, 1);
    set_reg(REG_Y_COUNT, 1);
    set_reg(REG_Z_COUNT, 1);
    wr_en <= 1'b0;
    send_word(1'b0);
    send_word(1'b0);

    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      drain();
      for (int a = 0; a < 3; a++) begin
        if ($urandom_range(0, 3) != 0) begin
          sz[a] = pick_size();
          set_reg(a[IDX_W-1:0], sz[a]);
        end
      end
      if ($urandom_range(0, 3) != 0) set_reg(REG_MIN_DIMS, $urandom_range(0, 3));
      wr_en <= 1'b0;
      grid_total = grid_side(sz[0]) * grid_side(sz[1]) * grid_side(sz[2]);
      if (grid_total <= 40 && $urandom_range(0, 1) == 0) count = grid_total + $urandom_range(1, 3);
      else count = $urandom_range(4, 40);
      send_word($urandom_range(0, 1));
      for (int w = 1; w < count; w++) send_word($urandom_range(0, 24) == 0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d words over %0d grid settings; %0d results compared, %0d marked last.",
             words_sent, settings_used, checked, wraps);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
